[rtl/fpmf_pkg.sv]
// Shared constants for the frame payload match filter: header offsets, register indexes, causes.
package fpmf_pkg;

	// Header geometry (bytes)
	localparam logic [7:0] ETH_LEN     = 8'd14;
	localparam logic [7:0] IP_PROTO    = 8'd9;
	localparam logic [7:0] IP_MIN_LEN  = 8'd20;
	localparam logic [7:0] TCP_MIN_LEN = 8'd20;
	localparam logic [7:0] TCP_DOFF    = 8'd12;
	localparam logic [7:0] UDP_LEN     = 8'd8;

	// IPv4 protocol numbers
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// Byte count and compare counter widths
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned IDX_W   = 6;

	// Configuration register indexes
	localparam int unsigned        REG_IDX_W          = 3;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
	localparam int unsigned        REG_DATA_W         = 64;

	// Verdict causes
	localparam logic [2:0] CAUSE_MATCHED   = 3'd0;
	localparam logic [2:0] CAUSE_SHORT_IP  = 3'd1;
	localparam logic [2:0] CAUSE_OTHER     = 3'd2;
	localparam logic [2:0] CAUSE_SHORT_TCP = 3'd3;
	localparam logic [2:0] CAUSE_TRUNCATED = 3'd4;
	localparam logic [2:0] CAUSE_MISMATCH  = 3'd5;

endpackage

[rtl/frame_payload_match_filter.sv]
// Frame payload match filter: buffers frame bytes and judges each frame at its last byte.
//
// Channel   Handshake            Fields
// input     start / busy         frame_byte[7:0], frame_end
// result    done (1-cycle)       pass_frame, verdict_cause[2:0]
// config    wr_en                wr_index[2:0], wr_data[63:0]
//
// A word without frame_end leaves busy low and the byte goes to the store.
// A word with frame_end raises busy while one store read port serves the header fields
// and then each payload byte, with a read step and a check step per compared byte.
// The verdict appears on done for one cycle, in the same cycle that busy drops; the receiver cannot stall it.
// Reset clears the byte count, the configuration and the sequencer; the store is not cleared.
module frame_payload_match_filter
	import fpmf_pkg::*;
#(
	parameter int unsigned PATTERN_BYTES     = 32,
	parameter int unsigned FRAME_STORE_BYTES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            frame_byte,
	input  logic                  frame_end,
	output logic                  done,
	output logic                  pass_frame,
	output logic [2:0]            verdict_cause,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [REG_DATA_W-1:0] wr_data
);

	localparam int unsigned AW = $clog2(FRAME_STORE_BYTES);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RD_IHL   = 3'd1;
	localparam logic [2:0] ST_RD_PROTO = 3'd2;
	localparam logic [2:0] ST_CHK      = 3'd3;
	localparam logic [2:0] ST_DOFF     = 3'd4;
	localparam logic [2:0] ST_CMP_RD   = 3'd5;
	localparam logic [2:0] ST_CMP_CHK  = 3'd6;

	logic [2:0]                 state_q;
	logic [COUNT_W-1:0]         bytes_seen_q;
	logic [COUNT_W-1:0]         len_q;
	logic [3:0]                 ihl_q;
	logic [7:0]                 start_q;
	logic [IDX_W-1:0]           idx_q;
	logic [IDX_W-1:0]           plen_q;
	logic [PATTERN_BYTES*8-1:0] pat_q;
	logic                       done_q;
	logic                       pass_q;
	logic [2:0]                 cause_q;

	logic [7:0] mem [FRAME_STORE_BYTES];
	logic [7:0] rdata_q;
	logic [AW-1:0] raddr;
	logic [7:0]    raddr8;

	logic              accept;
	logic [IDX_W-1:0]  count;
	logic [7:0]        ip_end;
	logic [7:0]        tcp_start;
	logic [7:0]        cmp_pos;
	logic [7:0]        pat_byte;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign count     = (plen_q > IDX_W'(PATTERN_BYTES)) ? IDX_W'(PATTERN_BYTES) : plen_q;
	assign tcp_start = ETH_LEN + {2'b00, ihl_q, 2'b00};
	assign ip_end    = tcp_start;
	assign cmp_pos   = start_q + {2'b00, idx_q};
	assign pat_byte  = pat_q[idx_q*8 +: 8];

	// Store read address per step
	always_comb begin
		case (state_q)
			ST_RD_IHL:   raddr8 = ETH_LEN;
			ST_RD_PROTO: raddr8 = ETH_LEN + IP_PROTO;
			ST_CHK:      raddr8 = tcp_start + TCP_DOFF;
			ST_CMP_RD:   raddr8 = cmp_pos;
			default:     raddr8 = ETH_LEN;
		endcase
		raddr = AW'(raddr8);
	end

	// Frame store: one write, one registered read
	always_ff @(posedge clk) begin
		if (accept && (bytes_seen_q < COUNT_W'(FRAME_STORE_BYTES))) begin
			mem[bytes_seen_q[AW-1:0]] <= frame_byte;
		end
		rdata_q <= mem[raddr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			pat_q  <= '0;
		end else if (wr_en) begin
			if (wr_index == REG_PATTERN_LENGTH) begin
				plen_q <= wr_data[IDX_W-1:0];
			end
			for (int b = 0; b < int'(PATTERN_BYTES); b++) begin
				if (wr_index == REG_PATTERN_WORD_0 + REG_IDX_W'(b >> 3)) begin
					pat_q[b*8 +: 8] <= wr_data[(b & 7)*8 +: 8];
				end
			end
		end
	end

	// Byte count and verdict sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bytes_seen_q <= '0;
			len_q        <= '0;
			ihl_q        <= '0;
			start_q      <= '0;
			idx_q        <= '0;
			done_q       <= 1'b0;
			pass_q       <= 1'b0;
			cause_q      <= CAUSE_MATCHED;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (frame_end) begin
							len_q        <= (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + 1'b1;
							bytes_seen_q <= '0;
							state_q      <= ST_RD_IHL;
						end else if (bytes_seen_q != '1) begin
							bytes_seen_q <= bytes_seen_q + 1'b1;
						end
					end
				end
				ST_RD_IHL: begin
					state_q <= ST_RD_PROTO;
				end
				ST_RD_PROTO: begin
					ihl_q   <= rdata_q[3:0];
					state_q <= ST_CHK;
				end
				// rdata_q holds the protocol byte here
				ST_CHK: begin
					idx_q <= '0;
					if (len_q < COUNT_W'(ETH_LEN + IP_MIN_LEN)) begin
						pass_q  <= 1'b0;
						cause_q <= CAUSE_SHORT_IP;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (rdata_q != PROTO_TCP && rdata_q != PROTO_UDP) begin
						pass_q  <= 1'b0;
						cause_q <= CAUSE_OTHER;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (rdata_q == PROTO_TCP) begin
						if (COUNT_W'(tcp_start) + COUNT_W'(TCP_MIN_LEN) > len_q) begin
							pass_q  <= 1'b0;
							cause_q <= CAUSE_SHORT_TCP;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DOFF;
						end
					end else begin
						start_q <= ip_end + UDP_LEN;
						state_q <= ST_CMP_RD;
					end
				end
				// rdata_q holds the TCP data offset byte
				ST_DOFF: begin
					start_q <= ip_end + {2'b00, rdata_q[7:4], 2'b00};
					state_q <= ST_CMP_RD;
				end
				ST_CMP_RD: begin
					if (idx_q == count) begin
						pass_q  <= 1'b0;
						cause_q <= CAUSE_MATCHED;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (COUNT_W'(cmp_pos) + 1'b1 > len_q) begin
						pass_q  <= 1'b0;
						cause_q <= CAUSE_TRUNCATED;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CMP_CHK;
					end
				end
				ST_CMP_CHK: begin
					if (rdata_q != pat_byte) begin
						pass_q  <= 1'b1;
						cause_q <= CAUSE_MISMATCH;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_CMP_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign pass_frame    = pass_q;
	assign verdict_cause = cause_q;

	// Checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) != ST_IDLE)
		else $error("verdict without a judging pass");

	a_pass_only_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pass_frame == (verdict_cause == CAUSE_MISMATCH)))
		else $error("pass flag disagrees with cause");

	a_end_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && frame_end) |=> busy)
		else $error("final word did not start a verdict");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP_RD || state_q == ST_CMP_CHK) |-> idx_q <= count)
		else $error("compare index ran past pattern length");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && frame_end) |=> bytes_seen_q == '0)
		else $error("byte count not cleared at frame end");

endmodule

[sim/frame_payload_match_filter_test.sv]
// Testbench for the frame payload match filter: directed and random frames checked against a local verdict predictor.
module frame_payload_match_filter_test
	import fpmf_pkg::*;
();

	localparam int unsigned PATTERN_BYTES     = 32;
	localparam int unsigned FRAME_STORE_BYTES = 256;
	// margin for the longest verdict walk, which reads and checks every pattern byte
	localparam int unsigned SETTLE_CYCLES     = 80;
	localparam int unsigned CYCLE_LIMIT       = 1000000;

	typedef struct packed {
		logic       forward;
		logic [2:0] cause;
	} verdict_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  start         = 1'b0;
	logic                  busy;
	logic [7:0]            frame_byte    = 8'h00;
	logic                  frame_end     = 1'b0;
	logic                  done;
	logic                  pass_frame;
	logic [2:0]            verdict_cause;
	logic                  wr_en         = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index      = REG_PATTERN_LENGTH;
	logic [REG_DATA_W-1:0] wr_data       = '0;

	// predictor state: configuration and a copy of the frame store
	logic [5:0]  cfg_length = '0;
	logic [63:0] cfg_pattern [4] = '{default: '0};
	logic [7:0]  frame_copy [FRAME_STORE_BYTES];
	logic [15:0] copy_count = '0;

	verdict_t    verdict_queue [$];
	logic [7:0]  frame_buf [$];
	int          payload_at;
	int          sender_idle_pct = 0;
	int          words_sent      = 0;
	int          error_count     = 0;
	int unsigned cycle_count     = 0;

	frame_payload_match_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.frame_byte    (frame_byte),
		.frame_end     (frame_end),
		.done          (done),
		.pass_frame    (pass_frame),
		.verdict_cause (verdict_cause),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [7:0] pattern_byte(input int unsigned k);
		return cfg_pattern[k >> 3][8 * (k & 7) +: 8];
	endfunction

	// Verdict for the frame now held in the store copy
	function automatic verdict_t judge_frame(input int unsigned len);
		verdict_t    v;
		int unsigned proto, ihl_len, l4_len, tcp_at, pay_start, count;
		v.forward = 1'b0;
		v.cause   = CAUSE_MATCHED;
		if (len < ETH_LEN + IP_MIN_LEN) begin
			v.cause = CAUSE_SHORT_IP;
			return v;
		end
		proto = frame_copy[ETH_LEN + IP_PROTO];
		if (proto != PROTO_TCP && proto != PROTO_UDP) begin
			v.cause = CAUSE_OTHER;
			return v;
		end
		ihl_len = frame_copy[ETH_LEN][3:0] * 4;
		if (proto == PROTO_TCP) begin
			tcp_at = ETH_LEN + ihl_len;
			if (tcp_at + TCP_MIN_LEN > len) begin
				v.cause = CAUSE_SHORT_TCP;
				return v;
			end
			l4_len = frame_copy[tcp_at + TCP_DOFF][7:4] * 4;
		end else begin
			l4_len = UDP_LEN;
		end
		pay_start = ETH_LEN + ihl_len + l4_len;
		count     = (cfg_length > PATTERN_BYTES) ? PATTERN_BYTES : cfg_length;
		for (int unsigned i = 0; i < count; i++) begin
			if (pay_start + i + 1 > len) begin
				v.cause = CAUSE_TRUNCATED;
				return v;
			end
			if (frame_copy[pay_start + i] != pattern_byte(i)) begin
				v.forward = 1'b1;
				v.cause   = CAUSE_MISMATCH;
				return v;
			end
		end
		return v;
	endfunction

	// Track one accepted word; a final word queues its verdict
	function automatic void record_word(input logic [7:0] value, input logic last);
		if (copy_count < FRAME_STORE_BYTES)
			frame_copy[copy_count] = value;
		if (copy_count != 16'hFFFF)
			copy_count++;
		if (last) begin
			verdict_queue.push_back(judge_frame(copy_count));
			copy_count = '0;
		end
	endfunction

	// Frame with headers laid out from the given fields and pat_bytes of pattern as payload
	function automatic void build_frame(input logic [7:0] proto, input logic [3:0] ihl,
			input logic [3:0] doff, input int pat_bytes, input int tail);
		int l4, total, tcp_at;
		tcp_at     = ETH_LEN + ihl * 4;
		l4         = (proto == PROTO_TCP) ? doff * 4 : UDP_LEN;
		payload_at = tcp_at + l4;
		total      = payload_at + pat_bytes + tail;
		if (total < 1)
			total = 1;
		frame_buf.delete();
		repeat (total) frame_buf.push_back(8'($urandom));
		for (int k = 0; k < pat_bytes; k++)
			if (payload_at + k < total)
				frame_buf[payload_at + k] = pattern_byte(k);
		// headers last, so overlapping payload never hides the protocol
		if (total > ETH_LEN)
			frame_buf[ETH_LEN] = {4'($urandom), ihl};
		if (total > ETH_LEN + IP_PROTO)
			frame_buf[ETH_LEN + IP_PROTO] = proto;
		if (proto == PROTO_TCP && total > tcp_at + TCP_DOFF)
			frame_buf[tcp_at + TCP_DOFF] = {doff, 4'($urandom)};
	endfunction

	function automatic void build_noise(input int len);
		frame_buf.delete();
		repeat (len) frame_buf.push_back(8'($urandom));
	endfunction

	function automatic void trim_frame(input int len);
		while (frame_buf.size() > len)
			void'(frame_buf.pop_back());
	endfunction

	function automatic void corrupt_payload(input int k);
		if (payload_at + k < frame_buf.size())
			frame_buf[payload_at + k] ^= 8'($urandom_range(1, 255));
	endfunction

	// Offer one word and hold it until the block takes it
	task automatic send_word(input logic [7:0] value, input logic last);
		while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		frame_byte <= value;
		frame_end  <= last;
		do @(posedge clk); while (busy);
		record_word(value, last);
		words_sent++;
	endtask

	task automatic send_frame();
		for (int k = 0; k < frame_buf.size(); k++)
			send_word(frame_buf[k], k == frame_buf.size() - 1);
	endtask

	// Hold off until every verdict is in and the sequencer has settled
	task automatic await_verdicts();
		start <= 1'b0;
		do @(posedge clk); while (verdict_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all five registers back to back while the block is idle
	task automatic configure(input logic [5:0] len, input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3);
		logic [REG_DATA_W-1:0] value [5];
		logic [REG_IDX_W-1:0]  index [5];
		await_verdicts();
		value[0] = {$urandom, $urandom};
		value[0][5:0] = len;
		index[0] = REG_PATTERN_LENGTH;
		value[1] = w0;
		value[2] = w1;
		value[3] = w2;
		value[4] = w3;
		for (int w = 0; w < 4; w++)
			index[w + 1] = REG_PATTERN_WORD_0 + REG_IDX_W'(w);
		for (int k = 0; k < 5; k++) begin
			wr_en    <= 1'b1;
			wr_index <= index[k];
			wr_data  <= value[k];
			@(posedge clk);
			if (index[k] == REG_PATTERN_LENGTH)
				cfg_length = value[k][5:0];
			else
				cfg_pattern[index[k] - REG_PATTERN_WORD_0] = value[k];
		end
		wr_en <= 1'b0;
	endtask

	// Reset configuration: zero length, so any frame reaching the payload matches
	task automatic test_reset_state();
		build_frame(PROTO_UDP, 4'd5, 4'd0, 0, 4);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 0, 0);
		send_frame();
	endtask

	// Short IPv4, foreign protocol and short TCP boundaries
	task automatic test_header_checks();
		build_noise(1);
		send_frame();
		build_noise(33);
		send_frame();
		build_frame(8'h00, 4'd5, 4'd0, 0, 0);
		trim_frame(34);
		send_frame();
		build_frame(8'hFF, 4'd5, 4'd0, 0, 0);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 0, 0);
		trim_frame(53);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 0, 0);
		send_frame();
		build_frame(PROTO_UDP, 4'd5, 4'd0, 0, 0);
		trim_frame(34);
		send_frame();
	endtask

	// IHL and data offset at and below their legal minimum, and at their maximum
	task automatic test_header_lengths();
		configure(6'd2, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		build_frame(PROTO_TCP, 4'd0, 4'd5, 2, 1);
		send_frame();
		build_frame(PROTO_UDP, 4'd15, 4'd0, 2, 0);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd0, 2, 3);
		send_frame();
		build_frame(PROTO_TCP, 4'd15, 4'd15, 2, 0);
		send_frame();
		build_frame(PROTO_UDP, 4'd1, 4'd0, 2, 2);
		send_frame();
	endtask

	// Full match, mismatch at either end, truncation, oversized and zero lengths
	task automatic test_pattern_compare();
		configure(6'd32, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		build_frame(PROTO_UDP, 4'd5, 4'd0, 32, 0);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 32, 2);
		corrupt_payload(0);
		send_frame();
		build_frame(PROTO_UDP, 4'd5, 4'd0, 32, 0);
		corrupt_payload(31);
		send_frame();
		build_frame(PROTO_UDP, 4'd5, 4'd0, 32, -1);
		send_frame();
		build_frame(PROTO_TCP, 4'd6, 4'd7, 32, -31);
		send_frame();
		configure(6'd63, '1, '1, '1, '1);
		build_frame(PROTO_TCP, 4'd5, 4'd5, 32, 0);
		send_frame();
		build_frame(PROTO_UDP, 4'd5, 4'd0, 32, 5);
		corrupt_payload(31);
		send_frame();
		configure(6'd33, '0, '0, '0, '0);
		build_frame(PROTO_UDP, 4'd5, 4'd0, 32, 0);
		send_frame();
		configure(6'd0, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		build_frame(PROTO_UDP, 4'd5, 4'd0, 0, 10);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 0, 0);
		send_frame();
	endtask

	// Frames past the store depth
	task automatic test_long_frames();
		configure(6'd8, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
		build_frame(PROTO_UDP, 4'd5, 4'd0, 8, 300 - 50);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 8, 270 - 62);
		corrupt_payload(7);
		send_frame();
		build_frame(PROTO_TCP, 4'd5, 4'd5, 8, 0);
		send_frame();
	endtask

	// Mostly well-formed frames with random headers and payload, some noise and broken frames
	task automatic test_random_traffic();
		int          idle_plan [3] = '{0, 69, 18};
		int          seg, kind, mode, count, tail;
		logic [7:0]  proto;
		logic [3:0]  ihl, doff;
		logic [5:0]  len;
		logic [63:0] w [4];
		seg = 0;
		while (seg < 6 || words_sent < 1700) begin
			for (int k = 0; k < 4; k++)
				w[k] = {$urandom, $urandom};
			case (seg)
				0: len = 6'd0;
				1: len = 6'd4;
				2: begin
					len = 6'd32;
					w   = '{default: '1};
				end
				3: len = 6'd63;
				4: len = 6'd1;
				5: begin
					len = 6'd33;
					w   = '{default: '0};
				end
				default: len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 8));
			endcase
			configure(len, w[0], w[1], w[2], w[3]);
			sender_idle_pct = idle_plan[seg % 3];
			count = (cfg_length > PATTERN_BYTES) ? PATTERN_BYTES : cfg_length;
			repeat (3) begin
				kind = $urandom_range(0, 99);
				mode = $urandom_range(0, 99);
				ihl  = ($urandom_range(0, 99) < 85) ? 4'd5 : 4'($urandom_range(0, 15));
				doff = ($urandom_range(0, 99) < 85) ? 4'd5 : 4'($urandom_range(0, 15));
				if (kind < 8) begin
					build_noise($urandom_range(1, 40));
				end else if (kind < 14) begin
					proto = 8'($urandom);
					if (proto == PROTO_TCP || proto == PROTO_UDP)
						proto = proto + 8'd1;
					build_frame(proto, ihl, doff, count, $urandom_range(0, 6));
				end else begin
					proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
					tail  = $urandom_range(0, 6);
					if (mode >= 70 && mode < 85 && count > 0)
						tail = -int'($urandom_range(1, count));
					build_frame(proto, ihl, doff, count, tail);
					if (mode >= 40 && mode < 70 && count > 0)
						corrupt_payload($urandom_range(0, count - 1));
					else if (mode >= 85)
						trim_frame(ETH_LEN + ihl * 4 + $urandom_range(0, 19));
				end
				send_frame();
			end
			seg++;
		end
		sender_idle_pct = 0;
	endtask

	// Compare each verdict with the oldest prediction
	always @(posedge clk) begin : check_verdicts
		verdict_t due;
		if (arst_n && done) begin
			if (verdict_queue.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, got pass_frame %0b cause %0d",
					$time, pass_frame, verdict_cause);
				error_count++;
			end else begin
				due = verdict_queue.pop_front();
				if (pass_frame !== due.forward) begin
					$display("%0t: pass_frame expected %0b got %0b", $time, due.forward,
						pass_frame);
					error_count++;
				end
				if (verdict_cause !== due.cause) begin
					$display("%0t: verdict_cause expected %0d got %0d", $time, due.cause,
						verdict_cause);
					error_count++;
				end
			end
		end
	end

	// Run-away guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_header_checks();
		test_header_lengths();
		test_pattern_compare();
		test_long_frames();
		test_random_traffic();
		await_verdicts();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
